/* rtl/ctt_pkg.sv */
// shared types and constants for the task tick table
package ctt_pkg;

    localparam int TICKS_W     = 29;
    localparam int DUE_W       = 8;
    localparam int MS_W        = 32;
    localparam int RES_CNT_W   = 5;
    localparam int MAX_RESULTS = 16;
    localparam int ENTRY_W     = 2 * TICKS_W + DUE_W;

    // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
    localparam logic [MS_W-1:0] TICK_RECIP  = 32'hCCCC_CCCD;
    localparam int              RECIP_SHIFT = 35;

    localparam logic [DUE_W-1:0] DUE_MAX = 8'd255;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_ADD  = 2'd1,
        KIND_DEL  = 2'd2,
        KIND_DISP = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV0,
        ST_DIV1,
        ST_DIV2,
        ST_START,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TICKS_W-1:0] delay;
        logic [TICKS_W-1:0] period;
        logic [DUE_W-1:0]   due;
    } entry_t;

    typedef struct packed {
        logic [3:0]       slot_index;
        logic             accepted;
        logic [DUE_W-1:0] due_count;
        logic             last;
    } res_t;

    localparam res_t RES_NONE = '{slot_index: 4'd0, accepted: 1'b0,
                                  due_count: 8'd0, last: 1'b1};

endpackage

/* rtl/ctt_if.sv */
// handshake channels for command and result words
interface ctt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [7:0]  slot_id;

    modport source (output valid, kind, delay_ms, period_ms, slot_id, input ready);
    modport sink   (input valid, kind, delay_ms, period_ms, slot_id, output ready);
    modport mon    (input valid, ready, kind, delay_ms, period_ms, slot_id);
endinterface

interface ctt_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot_index;
    logic       accepted;
    logic [7:0] due_count;
    logic       last;

    modport source (output valid, slot_index, accepted, due_count, last, input ready);
    modport sink   (input valid, slot_index, accepted, due_count, last, output ready);
    modport mon    (input valid, ready, slot_index, accepted, due_count, last);
endinterface

/* rtl/ctt_ram.sv */
// generic single-port-write, registered-read ram
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/cooperative_task_tick_table.sv */
// task tick table: one item at a time, table entries held in a ram
// add: two passes through one 32x32 multiplier before the result register
// tick and dispatch: one ram read per entry; tick writes each back, dispatch due ones
// delete: later entries move down one; none for the last entry or a rejected slot
// output stalls add cycles; a new word is taken only when the previous one is done
// reset clears the task count and output valid; table contents stay undefined
module cooperative_task_tick_table
    import ctt_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ctt_cmd_if.sink   cmd,
    ctt_res_if.source res
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    state_t               state_reg, state_next;
    kind_t                kind_reg;
    logic [MS_W-1:0]      dms_reg, pms_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     last_idx_reg, last_idx_next;
    logic [RES_CNT_W-1:0] nres_reg, nres_next;
    logic                 pend_valid_reg, pend_valid_next;
    res_t                 pend_reg, pend_next;
    res_t                 res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;
    logic [2*MS_W-1:0]    prod_reg;
    logic [TICKS_W-1:0]   qd_reg;

    logic [MS_W-1:0]      mul_a;
    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    entry_t               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               ent;
    logic                 out_free;
    logic                 adv;
    logic [7:0]           cnt8;
    res_t                 fin_res;

    function automatic logic [3:0] slot4(input logic [IDX_W-1:0] i);
        logic [IDX_W+3:0] w;
        w = {4'b0000, i};
        return w[3:0];
    endfunction

    ctt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent      = entry_t'(ram_rdata);
    assign out_free = !out_valid_reg || res.ready;
    assign cnt8     = 8'(cnt_reg);
    assign mul_a    = (state_reg == ST_DIV0) ? dms_reg : pms_reg;

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.slot_index = out_reg.slot_index;
    assign res.accepted   = out_reg.accepted;
    assign res.due_count  = out_reg.due_count;
    assign res.last       = out_reg.last;

    always_comb
    begin
        fin_res = res_reg;
        if (kind_reg == KIND_DISP)
        begin
            if (pend_valid_reg)
            begin
                fin_res      = pend_reg;
                fin_res.last = 1'b1;
            end
            else
            begin
                fin_res = RES_NONE;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        last_idx_next   = last_idx_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = idx_reg;
        ram_raddr       = idx_reg;
        ram_wdata       = ent;
        adv             = 1'b1;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    pend_valid_next = 1'b0;
                    nres_next       = '0;
                    res_next        = RES_NONE;
                    case (kind_t'(cmd.kind))
                        KIND_TICK, KIND_DISP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                idx_next      = '0;
                                last_idx_next = IDX_W'(cnt_reg - CNT_W'(1));
                                state_next    = ST_START;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (cnt_reg == CNT_W'(MAX_TASKS))
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_DIV0;
                            end
                        end
                        KIND_DEL:
                        begin
                            if (cmd.slot_id >= cnt8)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                res_next = '{slot_index: cmd.slot_id[3:0], accepted: 1'b1,
                                             due_count: 8'd0, last: 1'b1};
                                if (cmd.slot_id == cnt8 - 8'd1)
                                begin
                                    // removing the last entry moves nothing
                                    cnt_next   = cnt_reg - CNT_W'(1);
                                    state_next = ST_FINISH;
                                end
                                else
                                begin
                                    idx_next      = IDX_W'(cmd.slot_id) + IDX_W'(1);
                                    last_idx_next = IDX_W'(cnt_reg - CNT_W'(1));
                                    state_next    = ST_START;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_DIV0:
            begin
                state_next = ST_DIV1;
            end

            ST_DIV1:
            begin
                state_next = ST_DIV2;
            end

            ST_DIV2:
            begin
                ram_we           = 1'b1;
                ram_waddr        = IDX_W'(cnt_reg);
                ram_wdata.delay  = qd_reg;
                ram_wdata.period = prod_reg[2*MS_W-1:RECIP_SHIFT];
                ram_wdata.due    = '0;
                cnt_next         = cnt_reg + CNT_W'(1);
                res_next         = '{slot_index: slot4(IDX_W'(cnt_reg)), accepted: 1'b1,
                                     due_count: 8'd0, last: 1'b1};
                state_next       = ST_FINISH;
            end

            ST_START:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                case (kind_reg)
                    KIND_TICK:
                    begin
                        ram_we = 1'b1;
                        if (ent.delay != '0)
                        begin
                            ram_wdata.delay = ent.delay - TICKS_W'(1);
                        end
                        else
                        begin
                            ram_wdata.delay = ent.period;
                            if (ent.due != DUE_MAX)
                            begin
                                ram_wdata.due = ent.due + DUE_W'(1);
                            end
                        end
                    end
                    KIND_DEL:
                    begin
                        // entry moves one position down
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg - IDX_W'(1);
                    end
                    KIND_DISP:
                    begin
                        if (ent.due != '0 && nres_reg < RES_CNT_W'(MAX_RESULTS))
                        begin
                            if (pend_valid_reg && !out_free)
                            begin
                                adv = 1'b0;
                            end
                            else
                            begin
                                // held result goes out once a later one is found
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next       = pend_reg;
                                end
                                pend_valid_next = 1'b1;
                                pend_next       = '{slot_index: slot4(idx_reg), accepted: 1'b1,
                                                    due_count: ent.due, last: 1'b0};
                                nres_next       = nres_reg + RES_CNT_W'(1);
                                ram_we          = 1'b1;
                                ram_wdata.due   = '0;
                            end
                        end
                    end
                    default:
                    begin
                        adv = 1'b1;
                    end
                endcase

                if (adv)
                begin
                    if (idx_reg == last_idx_reg)
                    begin
                        if (kind_reg == KIND_DEL)
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next  = idx_reg + IDX_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = fin_res;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            nres_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            nres_reg       <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            kind_reg <= kind_t'(cmd.kind);
            dms_reg  <= cmd.delay_ms;
            pms_reg  <= cmd.period_ms;
        end
        if (state_reg == ST_DIV1)
        begin
            qd_reg <= prod_reg[2*MS_W-1:RECIP_SHIFT];
        end
        prod_reg     <= (2*MS_W)'(mul_a) * (2*MS_W)'(TICK_RECIP);
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        pend_reg     <= pend_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

/* rtl/ctt_checker.sv */
// port-level checks for the task tick table, bound to the top level
module ctt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [3:0] res_slot_index,
    input logic       res_accepted,
    input logic [7:0] res_due_count,
    input logic       res_last
);

    // a stalled result word stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // one word at a time: an accepted command is not followed by another at once
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one still in work");

    // a result that is not accepted (rejected, tick or empty dispatch) is a single final word with zero fields
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_accepted |-> res_last && res_slot_index == 4'd0
                                       && res_due_count == 8'd0)
        else $error("rejected result carries data");

    // a reported due count only comes with a successful dispatch word
    a_due_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_due_count != 8'd0 |-> res_accepted)
        else $error("due count on a rejected result");

    // while a dispatch still has words to send, no new command is taken
    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !cmd_ready)
        else $error("command taken in the middle of a dispatch burst");

endmodule

bind cooperative_task_tick_table ctt_checker u_ctt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_slot_index (res.slot_index),
    .res_accepted   (res.accepted),
    .res_due_count  (res.due_count),
    .res_last       (res.last)
);
